[hdl/ctb_pkg.sv]
package ctb_pkg;

    // Bank size and derived index widths.
    localparam int NUM_TIMERS = 16;
    localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

    // Field widths fixed by the interface.
    localparam int OP_W   = 3;
    localparam int ID_W   = 4;
    localparam int DUR_W  = 24;
    localparam int TIME_W = 32;

    // Command codes carried in the opcode field.
    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_START   = 3'd2,
        OP_RESTART = 3'd3,
        OP_STOP    = 3'd4,
        OP_DESTROY = 3'd5,
        OP_CHECK   = 3'd6
    } ctb_op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_RESTART_RD,
        ST_EXEC,
        ST_DONE
    } ctb_state_t;

    // Write port control for the per-slot payload memory.
    typedef struct packed {
        logic              en_dur;
        logic              en_rem;
        logic              en_stamp;
        logic [SLOT_W-1:0] addr;
        logic [DUR_W-1:0]  dur;
        logic [DUR_W-1:0]  rem;
        logic [TIME_W-1:0] stamp;
    } ctb_wr_t;

endpackage

[hdl/ctb_slot_ram.sv]
module ctb_slot_ram (
    input  logic                        aclk,
    input  ctb_pkg::ctb_wr_t            wr,
    input  logic [ctb_pkg::SLOT_W-1:0]  rd_addr,
    output logic [ctb_pkg::DUR_W-1:0]   rd_dur,
    output logic [ctb_pkg::DUR_W-1:0]   rd_rem,
    output logic [ctb_pkg::TIME_W-1:0]  rd_stamp
);
    import ctb_pkg::*;

    logic [DUR_W-1:0]  dur_mem   [NUM_TIMERS];
    logic [DUR_W-1:0]  rem_mem   [NUM_TIMERS];
    logic [TIME_W-1:0] stamp_mem [NUM_TIMERS];

    // Single write port with a separate enable per field.
    always_ff @(posedge aclk) begin
        if (wr.en_dur) begin
            dur_mem[wr.addr] <= wr.dur;
        end
        if (wr.en_rem) begin
            rem_mem[wr.addr] <= wr.rem;
        end
        if (wr.en_stamp) begin
            stamp_mem[wr.addr] <= wr.stamp;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_dur   <= dur_mem[rd_addr];
        rd_rem   <= rem_mem[rd_addr];
        rd_stamp <= stamp_mem[rd_addr];
    end

endmodule

[hdl/ctb_tick_alu.sv]
module ctb_tick_alu (
    input  logic [ctb_pkg::TIME_W-1:0] now_ms,
    input  logic [ctb_pkg::TIME_W-1:0] last_ms,
    input  logic [ctb_pkg::DUR_W-1:0]  remaining,
    output logic                       expired,
    output logic [ctb_pkg::DUR_W-1:0]  new_remaining
);
    import ctb_pkg::*;

    logic [TIME_W-1:0] elapsed;

    // Elapsed time wraps with the free-running millisecond counter.
    assign elapsed = now_ms - last_ms;

    // The timer expires once the elapsed time covers what is left.
    assign expired       = (elapsed >= TIME_W'(remaining));
    assign new_remaining = remaining - elapsed[DUR_W-1:0];

endmodule

[hdl/countdown_timer_bank.sv]
// Tick runs a sweep that takes every slot once through the shared subtract/compare
// unit. Create probes one slot per cycle until it finds a free one or reaches the
// last. One beat is processed at a time; the next is taken after the result is
// registered. Reset is synchronous, active low, and clears all slot flags and the
// sequencer; slot payload memory is not cleared.
module countdown_timer_bank (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ctb_pkg::OP_W-1:0]    s_opcode,
    input  logic [ctb_pkg::ID_W-1:0]    s_slot_id,
    input  logic [ctb_pkg::DUR_W-1:0]   s_duration_ms,
    input  logic                        s_run_now,
    input  logic [ctb_pkg::TIME_W-1:0]  s_now_ms,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ctb_pkg::ID_W-1:0]    m_result_id,
    output logic                        m_is_complete,
    output logic                        m_status
);
    import ctb_pkg::*;

    ctb_state_t state_reg, state_next;

    // Captured command.
    ctb_op_t            cmd_op_reg;
    logic [ID_W-1:0]    cmd_id_reg;
    logic [DUR_W-1:0]   cmd_dur_reg;
    logic               cmd_run_now_reg;
    logic [TIME_W-1:0]  cmd_now_reg;

    // Per-slot flags.
    logic [NUM_TIMERS-1:0] active_reg, active_next;
    logic [NUM_TIMERS-1:0] running_reg, running_next;
    logic [NUM_TIMERS-1:0] complete_reg, complete_next;

    // Scan and sweep bookkeeping.
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [SLOT_W-1:0] pend_slot_reg, pend_slot_next;

    // Pending result and output register.
    logic [ID_W-1:0] res_id_reg, res_id_next;
    logic            res_done_reg, res_done_next;
    logic            res_status_reg, res_status_next;
    logic            m_valid_reg;
    logic [ID_W-1:0] m_result_id_reg;
    logic            m_is_complete_reg;
    logic            m_status_reg;
    logic            m_load;

    logic              accept;
    logic [SLOT_W-1:0] cmd_slot;
    logic [SLOT_W-1:0] scan_slot;
    logic              cmd_in_range;
    logic              scan_free;
    logic              scan_last;

    ctb_wr_t           wr;
    logic [SLOT_W-1:0] rd_addr;
    logic [DUR_W-1:0]  rd_dur;
    logic [DUR_W-1:0]  rd_rem;
    logic [TIME_W-1:0] rd_stamp;
    logic              alu_expired;
    logic [DUR_W-1:0]  alu_new_rem;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign cmd_slot     = SLOT_W'(cmd_id_reg);
    assign cmd_in_range = (32'(cmd_id_reg) < 32'(NUM_TIMERS));
    assign scan_slot    = idx_reg[SLOT_W-1:0];
    assign scan_free    = !active_reg[scan_slot];
    assign scan_last    = (idx_reg == CNT_W'(NUM_TIMERS - 1));

    ctb_slot_ram u_ram (
        .aclk     (aclk),
        .wr       (wr),
        .rd_addr  (rd_addr),
        .rd_dur   (rd_dur),
        .rd_rem   (rd_rem),
        .rd_stamp (rd_stamp)
    );

    ctb_tick_alu u_alu (
        .now_ms        (cmd_now_reg),
        .last_ms       (rd_stamp),
        .remaining     (rd_rem),
        .expired       (alu_expired),
        .new_remaining (alu_new_rem)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (ctb_op_t'(s_opcode))
                        OP_TICK:    state_next = ST_SWEEP;
                        OP_CREATE:  state_next = ST_SCAN;
                        OP_RESTART: state_next = ST_RESTART_RD;
                        default:    state_next = ST_EXEC;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_free || scan_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP: begin
                if ((idx_reg == CNT_W'(NUM_TIMERS)) && !pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_RESTART_RD: state_next = ST_EXEC;
            ST_EXEC:       state_next = ST_DONE;
            ST_DONE: begin
                if (m_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control driven by the sequencer state.
    always_comb begin
        active_next     = active_reg;
        running_next    = running_reg;
        complete_next   = complete_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_slot_next  = pend_slot_reg;
        res_id_next     = res_id_reg;
        res_done_next   = res_done_reg;
        res_status_next = res_status_reg;
        m_load          = 1'b0;
        rd_addr         = cmd_slot;
        wr.en_dur       = 1'b0;
        wr.en_rem       = 1'b0;
        wr.en_stamp     = 1'b0;
        wr.addr         = cmd_slot;
        wr.dur          = cmd_dur_reg;
        wr.rem          = cmd_dur_reg;
        wr.stamp        = cmd_now_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next  = '0;
                pend_next = 1'b0;
                if (accept) begin
                    res_id_next     = s_slot_id;
                    res_done_next   = 1'b0;
                    res_status_next = 1'b0;
                end
            end
            ST_SCAN: begin
                // Probe one slot per cycle for the lowest free one.
                idx_next = idx_reg + 1'b1;
                if (scan_free) begin
                    active_next[scan_slot]   = 1'b1;
                    running_next[scan_slot]  = cmd_run_now_reg;
                    complete_next[scan_slot] = 1'b0;
                    wr.en_dur   = 1'b1;
                    wr.en_rem   = 1'b1;
                    wr.en_stamp = 1'b1;
                    wr.addr     = scan_slot;
                    res_id_next = ID_W'(idx_reg);
                end else if (scan_last) begin
                    res_status_next = 1'b1;
                    res_id_next     = '0;
                end
            end
            ST_SWEEP: begin
                // Issue the read of the next slot while the previous one is updated.
                rd_addr = scan_slot;
                if (idx_reg < CNT_W'(NUM_TIMERS)) begin
                    idx_next       = idx_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_slot_next = scan_slot;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && running_reg[pend_slot_reg]) begin
                    wr.addr     = pend_slot_reg;
                    wr.en_rem   = 1'b1;
                    wr.en_stamp = 1'b1;
                    if (alu_expired) begin
                        wr.rem                       = '0;
                        running_next[pend_slot_reg]  = 1'b0;
                        complete_next[pend_slot_reg] = 1'b1;
                    end else begin
                        wr.rem = alu_new_rem;
                    end
                end
            end
            ST_RESTART_RD: begin
                rd_addr = cmd_slot;
            end
            ST_EXEC: begin
                if (cmd_in_range) begin
                    case (cmd_op_reg)
                        OP_START: begin
                            running_next[cmd_slot]  = 1'b1;
                            complete_next[cmd_slot] = 1'b0;
                            wr.en_stamp = 1'b1;
                        end
                        OP_RESTART: begin
                            running_next[cmd_slot]  = 1'b1;
                            complete_next[cmd_slot] = 1'b0;
                            wr.en_stamp = 1'b1;
                            wr.en_rem   = 1'b1;
                            wr.rem      = rd_dur;
                        end
                        OP_STOP:    running_next[cmd_slot] = 1'b0;
                        OP_DESTROY: active_next[cmd_slot]  = 1'b0;
                        OP_CHECK:   res_done_next = complete_reg[cmd_slot];
                        default: ;
                    endcase
                end
            end
            ST_DONE: begin
                m_load = !m_valid_reg || m_ready;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= '0;
            running_reg  <= '0;
            complete_reg <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            running_reg  <= running_next;
            complete_reg <= complete_next;
            idx_reg      <= idx_next;
            pend_reg     <= pend_next;
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_op_reg      <= ctb_op_t'(s_opcode);
            cmd_id_reg      <= s_slot_id;
            cmd_dur_reg     <= s_duration_ms;
            cmd_run_now_reg <= s_run_now;
            cmd_now_reg     <= s_now_ms;
        end
        pend_slot_reg  <= pend_slot_next;
        res_id_reg     <= res_id_next;
        res_done_reg   <= res_done_next;
        res_status_reg <= res_status_next;
        if (m_load) begin
            m_result_id_reg   <= res_id_reg;
            m_is_complete_reg <= res_done_reg;
            m_status_reg      <= res_status_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_id   = m_result_id_reg;
    assign m_is_complete = m_is_complete_reg;
    assign m_status      = m_status_reg;

`ifndef ASSERT_OFF
    // A running timer is never also marked complete.
    a_run_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (running_reg & complete_reg) == '0)
        else $error("slot both running and complete");

    // A full status only appears when every slot is taken.
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && res_status_reg) |-> (&active_reg))
        else $error("full status with a free slot");

    // The slot counter never runs past the bank size.
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= CNT_W'(NUM_TIMERS))
        else $error("slot counter out of range");

    // One beat at a time: after an accept the input side closes.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second beat accepted while busy");
`endif

endmodule

[sim/countdown_timer_bank_test.sv]
`timescale 1ns / 1ps

module countdown_timer_bank_test;
    import ctb_pkg::*;

    // Opcode that the block leaves unused; it must only echo the timer id.
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    // Cycles the receiver holds off once to back the block up.
    localparam int HOLD_OFF_CYCLES = 300;
    // Quiet time after the last result, derived from the bank size.
    localparam int DRAIN_CYCLES = 2 * (NUM_TIMERS + 3);

    typedef struct {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   slot_id;
        logic [DUR_W-1:0]  duration_ms;
        logic              run_now;
        logic [TIME_W-1:0] now_ms;
    } timer_cmd_t;

    typedef struct {
        logic [ID_W-1:0] result_id;
        logic            is_complete;
        logic            status;
    } timer_reply_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_opcode;
    logic [ID_W-1:0]     s_slot_id;
    logic [DUR_W-1:0]    s_duration_ms;
    logic                s_run_now;
    logic [TIME_W-1:0]   s_now_ms;
    logic                m_valid;
    logic                m_ready;
    logic [ID_W-1:0]     m_result_id;
    logic                m_is_complete;
    logic                m_status;

    // Shadow copy of the timer bank.
    bit                  timer_active  [NUM_TIMERS];
    bit                  timer_running [NUM_TIMERS];
    bit                  timer_done    [NUM_TIMERS];
    logic [DUR_W-1:0]    timer_length  [NUM_TIMERS];
    logic [DUR_W-1:0]    timer_left    [NUM_TIMERS];
    logic [TIME_W-1:0]   timer_stamp   [NUM_TIMERS];

    timer_cmd_t          cmd_backlog[$];
    timer_reply_t        replies_due[$];
    timer_cmd_t          cur_cmd;
    bit                  beat_taken;
    bit                  hold_off;
    int unsigned         driven_count;
    int unsigned         mismatch_count;

    countdown_timer_bank dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_slot_id     (s_slot_id),
        .s_duration_ms (s_duration_ms),
        .s_run_now     (s_run_now),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_id   (m_result_id),
        .m_is_complete (m_is_complete),
        .m_status      (m_status)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one command to the shadow bank and return the reply it earns.
    function automatic timer_reply_t apply_command(timer_cmd_t c);
        timer_reply_t      r;
        logic [TIME_W-1:0] elapsed;
        int                slot;
        bit                found;
        bit                in_range;
        r.result_id   = c.slot_id;
        r.is_complete = 1'b0;
        r.status      = 1'b0;
        in_range      = (c.slot_id < NUM_TIMERS);
        found         = 1'b0;
        slot          = 0;
        case (c.opcode)
            OP_TICK: begin
                for (int s = 0; s < NUM_TIMERS; s++) begin
                    if (timer_running[s]) begin
                        elapsed = c.now_ms - timer_stamp[s];
                        if (elapsed >= {{(TIME_W-DUR_W){1'b0}}, timer_left[s]}) begin
                            timer_left[s]    = '0;
                            timer_done[s]    = 1'b1;
                            timer_running[s] = 1'b0;
                        end else begin
                            timer_left[s] = timer_left[s] - elapsed[DUR_W-1:0];
                        end
                        timer_stamp[s] = c.now_ms;
                    end
                end
            end
            OP_CREATE: begin
                for (int s = 0; s < NUM_TIMERS; s++) begin
                    if (!found && !timer_active[s]) begin
                        found = 1'b1;
                        slot  = s;
                    end
                end
                if (found) begin
                    timer_active[slot]  = 1'b1;
                    timer_running[slot] = c.run_now;
                    timer_done[slot]    = 1'b0;
                    timer_length[slot]  = c.duration_ms;
                    timer_left[slot]    = c.duration_ms;
                    timer_stamp[slot]   = c.now_ms;
                    r.result_id         = slot[ID_W-1:0];
                end else begin
                    r.status    = 1'b1;
                    r.result_id = '0;
                end
            end
            OP_START, OP_RESTART: begin
                if (in_range) begin
                    timer_running[c.slot_id] = 1'b1;
                    timer_done[c.slot_id]    = 1'b0;
                    if (c.opcode == OP_RESTART)
                        timer_left[c.slot_id] = timer_length[c.slot_id];
                    timer_stamp[c.slot_id] = c.now_ms;
                end
            end
            OP_STOP: begin
                if (in_range)
                    timer_running[c.slot_id] = 1'b0;
            end
            OP_DESTROY: begin
                if (in_range)
                    timer_active[c.slot_id] = 1'b0;
            end
            OP_CHECK: begin
                if (in_range && timer_done[c.slot_id])
                    r.is_complete = 1'b1;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Percentage of cycles one side idles, by phase of the run.
    function automatic int unsigned gap_pct(bit for_sender);
        int unsigned phase;
        phase = (driven_count / 128) % 4;
        case (phase)
            1: return for_sender ? 70 : 0;
            2: return for_sender ? 0 : 70;
            3: return 17;
            default: return 0;
        endcase
    endfunction

    task automatic queue_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                             logic [DUR_W-1:0] dur, logic run, logic [TIME_W-1:0] now);
        timer_cmd_t c;
        c.opcode      = op;
        c.slot_id     = id;
        c.duration_ms = dur;
        c.run_now     = run;
        c.now_ms      = now;
        cmd_backlog.push_back(c);
    endtask

    // Input driver: presents one beat at a time and holds it until taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !beat_taken) begin
            // Beat still waiting for ready; keep it steady.
        end else if (cmd_backlog.size() != 0 && $urandom_range(99) >= gap_pct(1'b1)) begin
            cur_cmd = cmd_backlog.pop_front();
            s_valid       <= 1'b1;
            s_opcode      <= cur_cmd.opcode;
            s_slot_id     <= cur_cmd.slot_id;
            s_duration_ms <= cur_cmd.duration_ms;
            s_run_now     <= cur_cmd.run_now;
            s_now_ms      <= cur_cmd.now_ms;
            driven_count++;
        end else begin
            s_valid <= 1'b0;
        end
        beat_taken = 1'b0;
    end

    // Result side ready, with random stalls and one long hold-off.
    always @(negedge aclk) begin
        if (!aresetn || hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= ($urandom_range(99) >= gap_pct(1'b0));
    end

    // Monitor: predicts on every accepted command and checks every result beat.
    always @(posedge aclk) begin
        timer_reply_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                beat_taken = 1'b1;
                replies_due.push_back(apply_command(cur_cmd));
            end
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: id %0d complete %0b status %0b",
                                 m_result_id, m_is_complete, m_status);
                end else begin
                    want = replies_due.pop_front();
                    if (m_result_id !== want.result_id || m_is_complete !== want.is_complete
                        || m_status !== want.status) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: expected id %0d complete %0b ",
                                      "status %0b, got id %0d complete %0b status %0b"},
                                     want.result_id, want.is_complete, want.status,
                                     m_result_id, m_is_complete, m_status);
                    end
                end
            end
        end
    end

    // Long receiver hold-off once the run is well under way.
    initial begin
        hold_off = 1'b0;
        wait (driven_count >= 400);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Watchdog.
    initial begin
        #20_000_000;
        $display("[countdown_timer_bank] ERROR");
        $finish;
    end

    // Stimulus, reset and end of run.
    initial begin
        logic [TIME_W-1:0] wall_ms;
        logic [DUR_W-1:0]  dur;
        logic [OP_W-1:0]   op;
        int unsigned       pick;

        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_opcode       = '0;
        s_slot_id      = '0;
        s_duration_ms  = '0;
        s_run_now      = 1'b0;
        s_now_ms       = '0;
        m_ready        = 1'b0;
        beat_taken     = 1'b0;
        driven_count   = 0;
        mismatch_count = 0;
        for (int s = 0; s < NUM_TIMERS; s++) begin
            timer_active[s]  = 1'b0;
            timer_running[s] = 1'b0;
            timer_done[s]    = 1'b0;
            timer_length[s]  = '0;
            timer_left[s]    = '0;
            timer_stamp[s]   = '0;
        end

        // Commands on slots that were never created: only flag reads and clears.
        queue_cmd(OP_CHECK, 4'd3, '0, 1'b0, 32'hFFFF_FFF0);
        queue_cmd(OP_STOP, 4'd15, '0, 1'b0, 32'hFFFF_FFF0);
        queue_cmd(OP_UNUSED, 4'd10, 24'hFFFFFF, 1'b1, 32'hFFFF_FFF0);
        queue_cmd(OP_TICK, 4'd0, '0, 1'b0, 32'hFFFF_FFF0);

        // Fill the bank just before the time counter wraps, then overflow it.
        queue_cmd(OP_CREATE, 4'd0, 24'd0, 1'b1, 32'hFFFF_FFF0);
        queue_cmd(OP_CREATE, 4'd0, 24'hFFFFFF, 1'b0, 32'hFFFF_FFF0);
        queue_cmd(OP_CREATE, 4'd0, 24'd5, 1'b1, 32'hFFFF_FFF0);
        for (int s = 3; s < NUM_TIMERS; s++)
            queue_cmd(OP_CREATE, 4'(s), 24'($urandom_range(10, 400)), 1'(s % 2),
                      32'hFFFF_FFF0);
        queue_cmd(OP_CREATE, 4'd7, 24'd7, 1'b1, 32'hFFFF_FFF0);

        // Tick across the wrap: the zero and short timers expire.
        queue_cmd(OP_TICK, 4'd0, '0, 1'b0, 32'h0000_0004);
        queue_cmd(OP_CHECK, 4'd0, '0, 1'b0, 32'h0000_0004);
        queue_cmd(OP_CHECK, 4'd2, '0, 1'b0, 32'h0000_0004);
        queue_cmd(OP_RESTART, 4'd2, '0, 1'b0, 32'h0000_0010);
        queue_cmd(OP_START, 4'd1, '0, 1'b0, 32'h0000_0010);
        queue_cmd(OP_STOP, 4'd2, '0, 1'b0, 32'h0000_0011);

        // A destroyed slot is the next one claimed.
        queue_cmd(OP_DESTROY, 4'd5, '0, 1'b0, 32'h0000_0012);
        queue_cmd(OP_CREATE, 4'd0, 24'd30, 1'b1, 32'h0000_0012);

        // Random traffic. Every slot has been written, so start and restart are legal
        // anywhere. Time mostly advances a little, with rare jumps anywhere.
        wall_ms = 32'h0000_0020;
        for (int n = 0; n < 1600; n++) begin
            if ($urandom_range(99) < 3)
                wall_ms = $urandom();
            else
                wall_ms = wall_ms + $urandom_range(0, 60);
            pick = $urandom_range(99);
            if (pick < 10)
                dur = '0;
            else if (pick < 20)
                dur = 24'($urandom());
            else if (pick < 30)
                dur = 24'($urandom_range(1, 2000));
            else
                dur = 24'($urandom_range(0, 300));
            pick = $urandom_range(99);
            if (pick < 30)
                op = OP_TICK;
            else if (pick < 45)
                op = OP_CREATE;
            else if (pick < 55)
                op = OP_START;
            else if (pick < 65)
                op = OP_RESTART;
            else if (pick < 73)
                op = OP_STOP;
            else if (pick < 85)
                op = OP_DESTROY;
            else if (pick < 98)
                op = OP_CHECK;
            else
                op = OP_UNUSED;
            queue_cmd(op, 4'($urandom_range(15)), dur, $urandom_range(99) < 75, wall_ms);
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for every command to go in and every reply to come out.
        while (cmd_backlog.size() != 0 || s_valid || replies_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("[countdown_timer_bank] OK");
        end else begin
            $display("[countdown_timer_bank] ERROR");
        end
        $finish;
    end

endmodule
